FILE: src/dcb_pkg.sv
// shared types, constants and width helpers of the dc blocker block
package dcb_pkg;

  localparam int DEF_FRACTION_BITS = 16;
  localparam int SAMPLE_W          = 16;
  localparam int GAIN_W            = 8;
  localparam int WORD_W            = 32;
  localparam int CFG_DATA_W        = 8;
  localparam int CFG_IDX_W         = 2;

  localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_STEREO = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_A,
    ST_PASS_B,
    ST_FIN,
    ST_OUT
  } seq_state_t;

  // per-cycle strobes from the sequencer to a lane
  typedef struct packed {
    logic load;
    logic a_run;
    logic a_emit;
    logic a_last;
    logic b_run;
    logic b_feed;
    logic b_keep;
    logic b_emit;
    logic b_low;
    logic fin;
    logic out_load;
  } lane_ctl_t;

  // magnitude bits of the filter state
  function automatic int mag_w(input int frac);
    return 25 + frac;
  endfunction

  // two's complement bits of the unsaturated filter sum
  function automatic int sum_w(input int frac);
    return 27 + frac;
  endfunction

endpackage

FILE: src/dcb_if.sv
// valid/ready channel interfaces for input frames and result words
interface dcb_frame_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dcb_pkg::SAMPLE_W-1:0]   sample_mic_one;
  logic signed [dcb_pkg::SAMPLE_W-1:0]   sample_mic_two;
  logic                                  end_of_block;

  modport source (output valid, sample_mic_one, sample_mic_two, end_of_block, input ready);
  modport sink   (input valid, sample_mic_one, sample_mic_two, end_of_block, output ready);
endinterface

interface dcb_word_if;
  logic                                valid;
  logic                                ready;
  logic signed [dcb_pkg::WORD_W-1:0]   out_mic_one;
  logic signed [dcb_pkg::WORD_W-1:0]   out_mic_two;
  logic                                last_out;

  modport source (output valid, out_mic_one, out_mic_two, last_out, input ready);
  modport sink   (input valid, out_mic_one, out_mic_two, last_out, output ready);
endinterface

FILE: src/dcb_ser_mul.sv
// serial-parallel multiplier: serial operand lsb first, parallel coefficient
module dcb_ser_mul #(
  parameter int COEF_W = dcb_pkg::DEF_FRACTION_BITS
) (
  input  logic              clk,
  input  logic              clear,
  input  logic              step,
  input  logic [COEF_W-1:0] coef,
  input  logic [COEF_W-1:0] init,
  input  logic              bit_in,
  output logic              bit_out
);

  logic [COEF_W-1:0] acc;
  logic [COEF_W:0]   sum;

  assign sum     = {1'b0, acc} + (bit_in ? {1'b0, coef} : {(COEF_W+1){1'b0}});
  assign bit_out = sum[0];

  // init adds a constant into the product, used for rounding
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= init;
    end else if (step) begin
      acc <= sum[COEF_W:1];
    end
  end

endmodule

FILE: src/dcb_seq.sv
// pass sequencer shared by both lanes
module dcb_seq #(
  parameter int FRACTION_BITS = dcb_pkg::DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_free,
  output logic               in_ready,
  output dcb_pkg::lane_ctl_t ctl
);

  localparam int MAG_W = dcb_pkg::mag_w(FRACTION_BITS);
  localparam int SUM_W = dcb_pkg::sum_w(FRACTION_BITS);
  localparam int LEN_A = FRACTION_BITS + SUM_W;
  localparam int LEN_B = SUM_W + dcb_pkg::GAIN_W;
  localparam int CNT_W = $clog2((LEN_A > LEN_B) ? LEN_A : LEN_B);

  dcb_pkg::seq_state_t state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcb_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      dcb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          cnt_next   = '0;
          state_next = dcb_pkg::ST_PASS_A;
        end
      end
      dcb_pkg::ST_PASS_A: begin
        ctl.a_run  = 1'b1;
        ctl.a_emit = (cnt >= CNT_W'(FRACTION_BITS));
        if (cnt == CNT_W'(LEN_A - 1)) begin
          ctl.a_last = 1'b1;
          cnt_next   = '0;
          state_next = dcb_pkg::ST_PASS_B;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      dcb_pkg::ST_PASS_B: begin
        ctl.b_run  = 1'b1;
        ctl.b_feed = (cnt < CNT_W'(SUM_W));
        ctl.b_keep = (cnt < CNT_W'(MAG_W));
        ctl.b_emit = (cnt >= CNT_W'(FRACTION_BITS));
        ctl.b_low  = (cnt < CNT_W'(FRACTION_BITS + dcb_pkg::SAMPLE_W));
        if (cnt == CNT_W'(LEN_B - 1)) begin
          cnt_next   = '0;
          state_next = dcb_pkg::ST_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      dcb_pkg::ST_FIN: begin
        ctl.fin    = 1'b1;
        state_next = dcb_pkg::ST_OUT;
      end
      dcb_pkg::ST_OUT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = dcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dcb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/dcb_lane.sv
// one bit-serial filter lane: dc blocker, gain, rounding and clip
module dcb_lane #(
  parameter int FRACTION_BITS = dcb_pkg::DEF_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dcb_pkg::lane_ctl_t                   ctl,
  input  logic signed [dcb_pkg::SAMPLE_W-1:0]  x,
  input  logic [dcb_pkg::GAIN_W-1:0]           gain,
  output logic [dcb_pkg::SAMPLE_W-1:0]         result
);

  localparam int MAG_W = dcb_pkg::mag_w(FRACTION_BITS);
  localparam int SUM_W = dcb_pkg::sum_w(FRACTION_BITS);
  localparam int SW    = dcb_pkg::SAMPLE_W;
  localparam int EXT_W = SUM_W - SW - 1 - FRACTION_BITS;
  localparam logic [FRACTION_BITS-1:0] COEF =
    FRACTION_BITS'(((64'd995 << FRACTION_BITS) + 64'd500) / 64'd1000);
  localparam logic [FRACTION_BITS-1:0] HALF = {1'b1, {(FRACTION_BITS-1){1'b0}}};

  // filter state, kept as sign and magnitude
  logic [MAG_W-1:0]    ym_sr;
  logic                yp_neg;
  logic [SW-1:0]       xp;

  logic [SUM_W-1:0]    add_sr;
  logic                carry;
  logic [SUM_W-1:0]    y_sr;
  logic                y_neg;
  logic                seen;
  logic                ovf;
  logic                hi;
  logic [SW-1:0]       mi_sr;

  logic [SW:0]         d;
  logic                dec_bit;
  logic                gain_bit;
  logic                b_add;
  logic                sum_bit;
  logic                carry_next;
  logic                mag_bit;
  logic [SW-1:0]       mi_neg;
  logic                over_pos;
  logic                over_neg;
  logic [SW-1:0]       clip;

  dcb_ser_mul #(.COEF_W(FRACTION_BITS)) u_decay (
    .clk     (clk),
    .clear   (ctl.load),
    .step    (ctl.a_run),
    .coef    (COEF),
    .init    (HALF),
    .bit_in  (ym_sr[0]),
    .bit_out (dec_bit)
  );

  dcb_ser_mul #(.COEF_W(FRACTION_BITS)) u_gain (
    .clk     (clk),
    .clear   (ctl.load),
    .step    (ctl.b_run),
    .coef    (FRACTION_BITS'(gain)),
    .init    (HALF),
    .bit_in  (mag_bit),
    .bit_out (gain_bit)
  );

  assign d = {x[SW-1], x} - {xp[SW-1], xp};

  // serial add of the input step and the signed decay term
  assign b_add      = dec_bit ^ yp_neg;
  assign sum_bit    = add_sr[0] ^ b_add ^ carry;
  assign carry_next = (add_sr[0] & b_add) | (add_sr[0] & carry) | (b_add & carry);

  // serial two's complement to magnitude: invert above the first one
  assign mag_bit = ctl.b_feed & (y_sr[0] ^ (y_neg & seen));

  assign mi_neg   = (~mi_sr) + {{(SW-1){1'b0}}, 1'b1};
  assign over_pos = hi | mi_sr[SW-1];
  assign over_neg = hi | (mi_sr[SW-1] & (|mi_sr[SW-2:0]));
  assign clip     = y_neg ? (over_neg ? dcb_pkg::SAT_NEG : mi_neg)
                          : (over_pos ? dcb_pkg::SAT_POS : mi_sr);

  always_ff @(posedge clk) begin
    if (rst) begin
      ym_sr  <= '0;
      yp_neg <= 1'b0;
      xp     <= '0;
    end else begin
      if (ctl.load) begin
        xp <= x;
      end
      if (ctl.a_run) begin
        ym_sr <= {1'b0, ym_sr[MAG_W-1:1]};
      end else if (ctl.b_keep) begin
        ym_sr <= {mag_bit, ym_sr[MAG_W-1:1]};
      end else if (ctl.fin && ovf) begin
        ym_sr <= '1;
      end
      if (ctl.fin) begin
        yp_neg <= y_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      add_sr <= {{EXT_W{d[SW]}}, d, {FRACTION_BITS{1'b0}}};
      carry  <= yp_neg;
      seen   <= 1'b0;
      ovf    <= 1'b0;
      hi     <= 1'b0;
    end
    if (ctl.a_emit) begin
      add_sr <= {add_sr[SUM_W-1], add_sr[SUM_W-1:1]};
      carry  <= carry_next;
      y_sr   <= {sum_bit, y_sr[SUM_W-1:1]};
    end
    if (ctl.a_last) begin
      y_neg <= sum_bit;
    end
    if (ctl.b_feed) begin
      y_sr <= {1'b0, y_sr[SUM_W-1:1]};
      seen <= seen | y_sr[0];
      if (!ctl.b_keep) begin
        ovf <= ovf | mag_bit;
      end
    end
    if (ctl.b_emit) begin
      if (ctl.b_low) begin
        mi_sr <= {gain_bit, mi_sr[SW-1:1]};
      end else begin
        hi <= hi | gain_bit;
      end
    end
    if (ctl.fin) begin
      result <= clip;
    end
  end

endmodule

FILE: src/dual_lane_dc_blocker_gain_clip_unit.sv
// top level of the two-lane dc blocker with gain and clipping
// Frames are taken one at a time, only in the idle state. Each frame runs
// through two bit-serial passes per lane: the first shifts the stored
// filter magnitude through a serial multiplier by the 0.995 coefficient and
// adds the input step serially, the second turns the sum into a magnitude,
// saves the new state and shifts it through a serial multiplier by the gain;
// a finishing state then clips, and an output state loads the output
// register and returns to idle, where the next frame is taken. In stereo
// mode both lanes run side by side. The next frame is taken while a result
// still waits in the output register; a frame that finishes before that
// word is taken waits for it. The filter state starts at zero after reset,
// no clearing pass. Registers are to be written only while no frame is in
// flight; the block itself does not enforce this.
module dual_lane_dc_blocker_gain_clip_unit #(
  parameter int FRACTION_BITS = dcb_pkg::DEF_FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  dcb_frame_if.sink                        frames,
  dcb_word_if.source                       words,
  input  logic                             wr_en,
  input  logic [dcb_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [dcb_pkg::CFG_DATA_W-1:0]   wr_data
);

  localparam int SW = dcb_pkg::SAMPLE_W;
  localparam int WW = dcb_pkg::WORD_W;

  // configuration registers
  logic [dcb_pkg::GAIN_W-1:0] gain;
  logic                       stereo;
  logic [dcb_pkg::GAIN_W-1:0] gain_eff;

  dcb_pkg::lane_ctl_t ctl;
  dcb_pkg::lane_ctl_t ctl_two;
  logic               in_ready;
  logic               out_free;

  logic [SW-1:0]      res_one;
  logic [SW-1:0]      res_two;
  logic               last;

  // output register
  logic               out_valid;
  logic [WW-1:0]      out_one;
  logic [WW-1:0]      out_two;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= dcb_pkg::GAIN_W'(1);
      stereo <= 1'b0;
    end else if (wr_en) begin
      case (dcb_pkg::reg_idx_t'(wr_index))
        dcb_pkg::REG_GAIN:   gain   <= wr_data[dcb_pkg::GAIN_W-1:0];
        dcb_pkg::REG_STEREO: stereo <= wr_data[0];
        default: ;
      endcase
    end
  end

  // a gain of zero behaves as unity
  assign gain_eff = (gain == '0) ? dcb_pkg::GAIN_W'(1) : gain;

  assign out_free     = !out_valid || words.ready;
  assign frames.ready = in_ready;

  dcb_seq #(.FRACTION_BITS(FRACTION_BITS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frames.valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // lane two sits still in mono so its state carries over a mode change
  assign ctl_two = stereo ? ctl : '0;

  dcb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_one (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .x      (frames.sample_mic_one),
    .gain   (gain_eff),
    .result (res_one)
  );

  dcb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_two (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl_two),
    .x      (frames.sample_mic_two),
    .gain   (gain_eff),
    .result (res_two)
  );

  // end-of-block flag rides along with the frame
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last <= frames.end_of_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (words.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sample goes to the high half of the word; mono copies lane one
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_one  <= {res_one, {(WW-SW){1'b0}}};
      out_two  <= {(stereo ? res_two : res_one), {(WW-SW){1'b0}}};
      out_last <= last;
    end
  end

  assign words.valid       = out_valid;
  assign words.out_mic_one = out_one;
  assign words.out_mic_two = out_two;
  assign words.last_out    = out_last;

endmodule
